/* src/pqs_pkg.sv */
// ----------------------------------------------------------------------------
// Patch quilting synthesizer package
// Transfer types, operation codes, register indexes, sequencer states and
// small arithmetic helpers shared by the synthesizer.
// ----------------------------------------------------------------------------
package pqs_pkg;

  localparam int MAX_SOURCE  = 64;
  localparam int SRC_XW      = $clog2(MAX_SOURCE);
  localparam int SRC_AW      = 2 * SRC_XW;
  localparam int SRC_DEPTH   = MAX_SOURCE * MAX_SOURCE;
  localparam int CANVAS_SIDE = 128;
  localparam int CAN_XW      = $clog2(CANVAS_SIDE);
  localparam int CAN_AW      = 2 * CAN_XW;
  localparam int CAN_DEPTH   = CANVAS_SIDE * CANVAS_SIDE;
  localparam int MAX_BLOCK   = 16;
  localparam int GRID_LAST   = 5;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_BLK_W = 2'd2;
  localparam logic [1:0] REG_BLK_H = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  pos_x;
    logic [6:0]  pos_y;
    logic [31:0] pixel_in;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] pixel_out;
    logic [6:0]  canvas_width;
    logic [6:0]  canvas_height;
  } rsp_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_BSTART = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_DRAIN  = 7'b0001000,
    ST_COPY   = 7'b0010000,
    ST_FLUSH  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  function automatic logic [4:0] clamp_blk(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (v < 5'd2) r = 5'd2;
    else if (v > 5'(MAX_BLOCK)) r = 5'(MAX_BLOCK);
    return r;
  endfunction

  // floor(5*v/6) for v up to 16, as a multiply by 215/256.
  function automatic logic [3:0] step_of(input logic [4:0] v);
    logic [12:0] prod;
    prod = 13'(v) * 13'd215;
    return prod[11:8];
  endfunction

  function automatic logic [7:0] chan_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [9:0] diff_sum(input logic [31:0] a, input logic [31:0] b);
    return 10'(chan_diff(a[23:16], b[23:16])) + 10'(chan_diff(a[15:8], b[15:8]))
         + 10'(chan_diff(a[7:0], b[7:0]));
  endfunction

endpackage

/* src/patch_quilting_synthesizer.sv */
// ----------------------------------------------------------------------------
// Patch quilting synthesizer
// Loads a source texture, tiles a 6 x 6 grid of least-cost blocks onto a
// canvas and returns canvas pixels on request.
// ----------------------------------------------------------------------------
// Commands arrive on cmd_valid/cmd_ready, results leave on rsp_valid/rsp_ready.
// A load transfer writes one source pixel and gives no result.
// A read transfer gives one result through the canvas read register and the
// output register; reads may follow each other every cycle, limited by the
// one-entry read stage and the output register when the receiver stalls.
// A run transfer gives one finish result. In a scan the canvas read port takes
// one block pixel per cycle, of which only overlap pixels add to the cost; in
// a copy the source port gives one copied pixel per cycle.
// No command is taken while a run is in progress.
// Reset clears the control state, the canvas size and sets the registers to
// their defaults; source pixels are undefined until loaded.
// A stalled receiver holds the output register; commands keep flowing until
// a second result would need it.
// ----------------------------------------------------------------------------
module patch_quilting_synthesizer (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  pqs_pkg::cmd_t  cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pqs_pkg::rsp_t  rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic [31:0] source_mem [pqs_pkg::SRC_DEPTH];
  logic [31:0] canvas_mem [pqs_pkg::CAN_DEPTH];
  logic [31:0] source_q;
  logic [31:0] canvas_q;

  logic [6:0] src_w_reg, src_h_reg;
  logic [4:0] blk_w_reg, blk_h_reg;

  pqs_pkg::state_t state;

  logic [4:0] bw, bh;
  logic [3:0] sw, sh;
  logic [6:0] wlim, hlim;
  logic [2:0] i_idx, j_idx;
  logic [6:0] cx, cy;
  logic [5:0] p, q;
  logic [3:0] dx, dy;
  logic       found;
  logic [11:0] best_cost, cost_acc;
  logic [5:0] best_x, best_y;
  logic [6:0] out_width, out_height;

  logic       s1_v, s1_use, s1_ok;
  logic       s2_v;
  logic [9:0] s2_sum;
  logic       s3_v;
  logic [2:0] s3_quot;
  logic       c1_v, c1_ok;
  logic [pqs_pkg::CAN_AW-1:0] c1_addr;

  logic       rd_pend, rd_inr;

  logic       cmd_fire, rd_move, out_free, cfg_wr;
  logic [4:0] bw_c, bh_c;
  logic [3:0] sw_c, sh_c;
  logic [6:0] sx, sy, kx, ky;
  logic       src_ok, overlap, pipe_empty, last_dy, last_dx;
  logic [22:0] quot_prod;
  logic [7:0] p_next_end, q_next_end;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign out_free  = !rsp_valid || rsp_ready;
  assign rd_move   = rd_pend && out_free;
  assign cmd_ready = (state == pqs_pkg::ST_IDLE) && (!rd_pend || rd_move);
  assign cmd_fire  = cmd_valid && cmd_ready;

  always_comb begin
    unique case (paddr[3:2])
      pqs_pkg::REG_SRC_W: prdata = {25'd0, src_w_reg};
      pqs_pkg::REG_SRC_H: prdata = {25'd0, src_h_reg};
      pqs_pkg::REG_BLK_W: prdata = {27'd0, blk_w_reg};
      pqs_pkg::REG_BLK_H: prdata = {27'd0, blk_h_reg};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w_reg <= 7'd64;
      src_h_reg <= 7'd64;
      blk_w_reg <= 5'd8;
      blk_h_reg <= 5'd8;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        pqs_pkg::REG_SRC_W: src_w_reg <= pwdata[6:0];
        pqs_pkg::REG_SRC_H: src_h_reg <= pwdata[6:0];
        pqs_pkg::REG_BLK_W: blk_w_reg <= pwdata[4:0];
        pqs_pkg::REG_BLK_H: blk_h_reg <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  assign bw_c = pqs_pkg::clamp_blk(blk_w_reg);
  assign bh_c = pqs_pkg::clamp_blk(blk_h_reg);
  assign sw_c = pqs_pkg::step_of(bw_c);
  assign sh_c = pqs_pkg::step_of(bh_c);

  always_comb begin
    if (state == pqs_pkg::ST_COPY) begin
      sx = 7'(best_x) + 7'(dx);
      sy = 7'(best_y) + 7'(dy);
    end else begin
      sx = 7'(p) + 7'(dx);
      sy = 7'(q) + 7'(dy);
    end
    kx = cx + 7'(dx);
    ky = cy + 7'(dy);
  end

  assign src_ok  = (sx < wlim) && (sy < hlim);
  assign overlap = ((i_idx != 3'd0) && (5'(dx) < (bw - 5'(sw))))
                || ((j_idx != 3'd0) && (5'(dy) < (bh - 5'(sh))));
  assign pipe_empty = !s1_v && !s2_v && !s3_v;
  assign last_dy = (5'(dy) == bw - bw + bh - 5'd1);
  assign last_dx = (5'(dx) == bw - 5'd1);
  assign quot_prod = 23'(s2_sum) * 23'd5243;
  assign p_next_end = 8'(p) + 8'(sw) + 8'(bw);
  assign q_next_end = 8'(q) + 8'(sh) + 8'(bh);

  always_ff @(posedge clk) begin
    if (cmd_fire && cmd.op == pqs_pkg::OP_LOAD
        && cmd.pos_x < 7'(pqs_pkg::MAX_SOURCE) && cmd.pos_y < 7'(pqs_pkg::MAX_SOURCE))
      source_mem[{cmd.pos_y[pqs_pkg::SRC_XW-1:0], cmd.pos_x[pqs_pkg::SRC_XW-1:0]}]
        <= cmd.pixel_in;
    if (state == pqs_pkg::ST_SCAN || state == pqs_pkg::ST_COPY)
      source_q <= source_mem[{sy[pqs_pkg::SRC_XW-1:0], sx[pqs_pkg::SRC_XW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (c1_v)
      canvas_mem[c1_addr] <= c1_ok ? source_q : 32'd0;
    if (state == pqs_pkg::ST_SCAN)
      canvas_q <= canvas_mem[{ky, kx}];
    else if (cmd_fire && cmd.op == pqs_pkg::OP_READ)
      canvas_q <= canvas_mem[{cmd.pos_y, cmd.pos_x}];
  end

  always_ff @(posedge clk) begin
    s1_use  <= overlap;
    s1_ok   <= src_ok;
    s2_sum  <= pqs_pkg::diff_sum(canvas_q, s1_ok ? source_q : 32'd0);
    s3_quot <= quot_prod[21:19];
    c1_ok   <= src_ok;
    c1_addr <= {ky, kx};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      c1_v <= 1'b0;
    end else begin
      s1_v <= (state == pqs_pkg::ST_SCAN);
      s2_v <= s1_v && s1_use;
      s3_v <= s2_v;
      c1_v <= (state == pqs_pkg::ST_COPY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else if (cmd_fire && cmd.op == pqs_pkg::OP_READ) begin
      rd_pend <= 1'b1;
    end else if (rd_move) begin
      rd_pend <= 1'b0;
    end
    if (cmd_fire)
      rd_inr <= (cmd.pos_x < out_width) && (cmd.pos_y < out_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rd_move) begin
      rsp_valid         <= 1'b1;
      rsp.kind          <= pqs_pkg::KIND_READ;
      rsp.pixel_out     <= rd_inr ? canvas_q : 32'd0;
      rsp.canvas_width  <= out_width;
      rsp.canvas_height <= out_height;
    end else if (state == pqs_pkg::ST_DONE && out_free) begin
      rsp_valid         <= 1'b1;
      rsp.kind          <= pqs_pkg::KIND_DONE;
      rsp.pixel_out     <= 32'd0;
      rsp.canvas_width  <= out_width;
      rsp.canvas_height <= out_height;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pqs_pkg::ST_IDLE;
      out_width  <= 7'd0;
      out_height <= 7'd0;
      best_cost  <= 12'd0;
      best_x     <= 6'd0;
      best_y     <= 6'd0;
      cost_acc   <= 12'd0;
      found      <= 1'b0;
    end else begin
      if (s3_v)
        cost_acc <= cost_acc + 12'(s3_quot);
      unique case (state)
        pqs_pkg::ST_IDLE: begin
          if (cmd_fire && cmd.op == pqs_pkg::OP_RUN) begin
            bw         <= bw_c;
            bh         <= bh_c;
            sw         <= sw_c;
            sh         <= sh_c;
            wlim       <= (src_w_reg > 7'(pqs_pkg::MAX_SOURCE)) ? 7'(pqs_pkg::MAX_SOURCE)
                                                               : src_w_reg;
            hlim       <= (src_h_reg > 7'(pqs_pkg::MAX_SOURCE)) ? 7'(pqs_pkg::MAX_SOURCE)
                                                               : src_h_reg;
            out_width  <= 7'(7'(sw_c) * 7'd5) + 7'(bw_c);
            out_height <= 7'(7'(sh_c) * 7'd5) + 7'(bh_c);
            i_idx      <= 3'd0;
            j_idx      <= 3'd0;
            cx         <= 7'd0;
            cy         <= 7'd0;
            state      <= pqs_pkg::ST_BSTART;
          end
        end
        pqs_pkg::ST_BSTART: begin
          found     <= 1'b0;
          best_cost <= 12'd0;
          best_x    <= 6'd0;
          best_y    <= 6'd0;
          p         <= 6'd0;
          q         <= 6'd0;
          dx        <= 4'd0;
          dy        <= 4'd0;
          cost_acc  <= 12'd0;
          if ((7'(bw) < wlim) && (7'(bh) < hlim)) state <= pqs_pkg::ST_SCAN;
          else state <= pqs_pkg::ST_COPY;
        end
        pqs_pkg::ST_SCAN: begin
          if (last_dy) begin
            dy <= 4'd0;
            if (last_dx) begin
              dx    <= 4'd0;
              state <= pqs_pkg::ST_DRAIN;
            end else begin
              dx <= dx + 4'd1;
            end
          end else begin
            dy <= dy + 4'd1;
          end
        end
        pqs_pkg::ST_DRAIN: begin
          if (pipe_empty) begin
            if (!found || cost_acc < best_cost) begin
              found     <= 1'b1;
              best_cost <= cost_acc;
              best_x    <= p;
              best_y    <= q;
            end
            cost_acc <= 12'd0;
            if (q_next_end < 8'(hlim)) begin
              q     <= q + 6'(sh);
              state <= pqs_pkg::ST_SCAN;
            end else if (p_next_end < 8'(wlim)) begin
              p     <= p + 6'(sw);
              q     <= 6'd0;
              state <= pqs_pkg::ST_SCAN;
            end else begin
              state <= pqs_pkg::ST_COPY;
            end
          end
        end
        pqs_pkg::ST_COPY: begin
          if (last_dy) begin
            dy <= 4'd0;
            if (last_dx) begin
              dx <= 4'd0;
              if (j_idx == 3'(pqs_pkg::GRID_LAST)) begin
                j_idx <= 3'd0;
                cy    <= 7'd0;
                if (i_idx == 3'(pqs_pkg::GRID_LAST)) begin
                  state <= pqs_pkg::ST_FLUSH;
                end else begin
                  i_idx <= i_idx + 3'd1;
                  cx    <= cx + 7'(sw);
                  state <= pqs_pkg::ST_BSTART;
                end
              end else begin
                j_idx <= j_idx + 3'd1;
                cy    <= cy + 7'(sh);
                state <= pqs_pkg::ST_BSTART;
              end
            end else begin
              dx <= dx + 4'd1;
            end
          end else begin
            dy <= dy + 4'd1;
          end
        end
        pqs_pkg::ST_FLUSH: begin
          state <= pqs_pkg::ST_DONE;
        end
        pqs_pkg::ST_DONE: begin
          if (out_free) state <= pqs_pkg::ST_IDLE;
        end
        default: state <= pqs_pkg::ST_IDLE;
      endcase
    end
  end

  a_busy_no_cmd: assert property (@(posedge clk) disable iff (rst)
    state != pqs_pkg::ST_IDLE |-> !cmd_ready)
    else $error("command accepted during a run");

  a_copy_write: assert property (@(posedge clk) disable iff (rst)
    c1_v |-> $past(state == pqs_pkg::ST_COPY))
    else $error("canvas write without a copy issue");

  a_cost_window: assert property (@(posedge clk) disable iff (rst)
    s3_v |-> (state == pqs_pkg::ST_SCAN || state == pqs_pkg::ST_DRAIN))
    else $error("cost accumulation outside a candidate scan");

endmodule
